>>> src/bcl_pkg.sv
// ----------------------------------------------------------------------------
// Button change lockout: shared package
// Types, codes, register indexes and reset values used by every file of the
// button change qualifier.
// ----------------------------------------------------------------------------
package bcl_pkg;

    // Default sizing of the button table.
    localparam int NUM_BUTTONS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed widths of the request and result fields.
    localparam int PIN_W    = 4;
    localparam int MASK_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CHANGE_W = 16;
    localparam int REG_IDX_W = 2;

    // Register reset values.
    localparam logic [MASK_W-1:0] LOCKOUT_RST = 16'd100;
    localparam logic [MASK_W-1:0] REVERSED_RST = 16'h0000;
    localparam logic [MASK_W-1:0] ENABLED_RST = 16'hFFFF;
    localparam logic [PIN_W-1:0]  PARK_PIN_RST = 4'd0;

    // Request commands.
    localparam logic CMD_SNAPSHOT = 1'b0;
    localparam logic CMD_EVENT    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LOCKOUT  = 2'd0,
        REG_REVERSED = 2'd1,
        REG_ENABLED  = 2'd2,
        REG_PARK_PIN = 2'd3
    } reg_idx_t;

    // Configuration as seen by the core.
    typedef struct packed {
        logic [MASK_W-1:0] lockout_ms;
        logic [MASK_W-1:0] reversed_mask;
        logic [MASK_W-1:0] enabled_mask;
        logic [PIN_W-1:0]  park_pin;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EV_CHECK,
        ST_SCAN,
        ST_SNAP_WR
    } state_t;

    // Address width of a table of n entries, at least one bit.
    function automatic int addr_bits(input int n);
        addr_bits = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> src/bcl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [bcl_pkg::addr_bits(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [bcl_pkg::addr_bits(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/bcl_cfg.sv
// ----------------------------------------------------------------------------
// Button change lockout: configuration registers
// Holds lockout time, polarity mask, enable mask and park pin.
// ----------------------------------------------------------------------------
module bcl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcl_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [bcl_pkg::MASK_W-1:0]      cfg_data,
    output bcl_pkg::cfg_t                   cfg
);

    bcl_pkg::cfg_t cfg_reg;
    bcl_pkg::cfg_t cfg_next;

    // Writes are taken only while no request is in progress or on offer, so a
    // write never lands in the same cycle as a request.
    assign cfg_ready = ~busy & ~start;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (bcl_pkg::reg_idx_t'(cfg_index))
                bcl_pkg::REG_LOCKOUT:  cfg_next.lockout_ms    = cfg_data;
                bcl_pkg::REG_REVERSED: cfg_next.reversed_mask = cfg_data;
                bcl_pkg::REG_ENABLED:  cfg_next.enabled_mask  = cfg_data;
                bcl_pkg::REG_PARK_PIN: cfg_next.park_pin      = cfg_data[bcl_pkg::PIN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms    <= bcl_pkg::LOCKOUT_RST;
            cfg_reg.reversed_mask <= bcl_pkg::REVERSED_RST;
            cfg_reg.enabled_mask  <= bcl_pkg::ENABLED_RST;
            cfg_reg.park_pin      <= bcl_pkg::PARK_PIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/bcl_core.sv
// ----------------------------------------------------------------------------
// Button change lockout: core sequencer
// Reads a button entry from the state RAM, qualifies or loads the new level,
// writes the entry back and issues the result.
// ----------------------------------------------------------------------------
module bcl_core #(
    parameter int NUM_BUTTONS = bcl_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_BITS  = bcl_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bcl_pkg::cfg_t                   cfg,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [bcl_pkg::PIN_W-1:0]       pin,
    input  logic                            level,
    input  logic [bcl_pkg::MASK_W-1:0]      pin_levels,
    input  logic [bcl_pkg::TIME_W-1:0]      time_ms,
    output logic                            done,
    output logic [bcl_pkg::PIN_W-1:0]       button,
    output logic                            pressed,
    output logic                            button_level,
    output logic [bcl_pkg::CHANGE_W-1:0]    changes,
    output logic                            park_led,
    output logic                            last
);

    localparam int AW = bcl_pkg::addr_bits(NUM_BUTTONS);
    localparam int W  = 1 + COUNT_BITS + bcl_pkg::TIME_W;

    bcl_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  idx_reg, idx_next;
    logic [bcl_pkg::MASK_W-1:0]     levels_reg;
    logic [bcl_pkg::TIME_W-1:0]     time_reg;
    logic                           ev_level_reg;
    logic [NUM_BUTTONS-1:0]         vld_reg;
    logic                           rd_vld_reg;
    logic                           park_led_reg;

    logic                           res_valid_reg;
    logic [bcl_pkg::PIN_W-1:0]      res_button_reg;
    logic                           res_pressed_reg;
    logic                           res_level_reg;
    logic [bcl_pkg::CHANGE_W-1:0]   res_changes_reg;
    logic                           res_park_reg;
    logic                           res_last_reg;

    logic                           accept;
    logic                           pin_ok;
    logic [NUM_BUTTONS-1:0]         btn_en;
    logic [NUM_BUTTONS-1:0]         above;
    logic                           idx_last;
    logic                           is_last;
    logic                           rd_en, wr_en, emit;
    logic [AW-1:0]                  rd_addr;
    logic [W-1:0]                   ram_q, rd_word, wr_data;
    logic                           rd_level;
    logic [COUNT_BITS-1:0]          rd_cnt, new_cnt;
    logic [bcl_pkg::TIME_W-1:0]     rd_stamp, elapsed;
    logic                           ev_ok;
    logic                           new_level;
    logic                           park_hit;
    logic                           park_now;
    logic                           last_flag;

    // Request decode in the idle state.
    assign busy   = (state_reg != bcl_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign btn_en = cfg.enabled_mask[NUM_BUTTONS-1:0];
    assign pin_ok = ({1'b0, pin} < (bcl_pkg::PIN_W+1)'(NUM_BUTTONS)) && cfg.enabled_mask[pin];

    // Snapshot walk: end of table and last enabled button.
    assign idx_last = (idx_reg == AW'(NUM_BUTTONS - 1));
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            above[i] = btn_en[i] && (AW'(i) > idx_reg);
        end
    end
    assign is_last = ~|above;

    // State RAM: {level, change count, stamp}; never-written entries read as zero.
    bcl_ram #(
        .WIDTH (W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign rd_word  = rd_vld_reg ? ram_q : '0;
    assign rd_level = rd_word[W-1];
    assign rd_cnt   = rd_word[bcl_pkg::TIME_W +: COUNT_BITS];
    assign rd_stamp = rd_word[bcl_pkg::TIME_W-1:0];

    // Change qualification: level differs and lockout has strictly passed.
    assign elapsed = time_reg - rd_stamp;
    assign ev_ok   = (rd_level != ev_level_reg)
                     && (elapsed > {{(bcl_pkg::TIME_W-bcl_pkg::MASK_W){1'b0}}, cfg.lockout_ms});

    // Modified entry.
    assign new_level = (state_reg == bcl_pkg::ST_SNAP_WR) ? levels_reg[idx_reg] : ev_level_reg;
    assign new_cnt   = rd_cnt + 1'b1;
    assign wr_data   = {new_level, new_cnt, time_reg};
    assign park_hit  = (bcl_pkg::PIN_W'(idx_reg) == cfg.park_pin);
    assign park_now  = park_hit ? ~new_level : park_led_reg;
    assign last_flag = (state_reg == bcl_pkg::ST_EV_CHECK) ? 1'b1 : is_last;

    // Sequencer outputs: RAM access, result issue and walk index.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        emit     = 1'b0;
        idx_next = idx_reg;
        unique case (state_reg)
            bcl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == bcl_pkg::CMD_SNAPSHOT)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = pin[AW-1:0];
                        rd_addr  = pin[AW-1:0];
                        rd_en    = pin_ok;
                    end
                end
            end
            bcl_pkg::ST_SCAN:
            begin
                if (btn_en[idx_reg])
                begin
                    rd_en = 1'b1;
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bcl_pkg::ST_EV_CHECK:
            begin
                wr_en = ev_ok;
                emit  = ev_ok;
            end
            bcl_pkg::ST_SNAP_WR:
            begin
                wr_en = 1'b1;
                emit  = 1'b1;
                if (!is_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == bcl_pkg::CMD_SNAPSHOT)
                    begin
                        state_next = bcl_pkg::ST_SCAN;
                    end
                    else if (pin_ok)
                    begin
                        state_next = bcl_pkg::ST_EV_CHECK;
                    end
                end
            end
            bcl_pkg::ST_SCAN:
            begin
                if (btn_en[idx_reg])
                begin
                    state_next = bcl_pkg::ST_SNAP_WR;
                end
                else if (idx_last)
                begin
                    state_next = bcl_pkg::ST_IDLE;
                end
            end
            bcl_pkg::ST_EV_CHECK:
            begin
                state_next = bcl_pkg::ST_IDLE;
            end
            bcl_pkg::ST_SNAP_WR:
            begin
                state_next = is_last ? bcl_pkg::ST_IDLE : bcl_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = bcl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcl_pkg::ST_IDLE;
            idx_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            park_led_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= emit;
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[idx_reg] <= 1'b1;
                park_led_reg     <= park_now;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg   <= pin_levels;
            time_reg     <= time_ms;
            ev_level_reg <= level;
        end
        if (emit)
        begin
            res_button_reg  <= bcl_pkg::PIN_W'(idx_reg);
            res_pressed_reg <= (new_level == cfg.reversed_mask[idx_reg]);
            res_level_reg   <= new_level;
            res_changes_reg <= bcl_pkg::CHANGE_W'(new_cnt);
            res_park_reg    <= park_now;
            res_last_reg    <= last_flag;
        end
    end

    assign done         = res_valid_reg;
    assign button       = res_button_reg;
    assign pressed      = res_pressed_reg;
    assign button_level = res_level_reg;
    assign changes      = res_changes_reg;
    assign park_led     = res_park_reg;
    assign last         = res_last_reg;

endmodule

>>> src/button_change_lockout_debounce_top.sv
// ----------------------------------------------------------------------------
// Button change lockout debounce: top level
// Qualifies button changes from a 16-pin expander and reports button states.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a clock edge with start high and busy low. command
// selects a full level snapshot (pin_levels, time_ms) or a single pin change
// event (pin, level, time_ms). Results appear on the result ports for one
// cycle each, marked by done; the receiver cannot stall them.
// A change event reads the button entry from the state RAM in its accept
// cycle; ST_EV_CHECK then qualifies it, writes it back and issues the
// result, which shows in the next cycle with last set. A rejected event
// gives no result; an event for a pin with no enabled button is dropped in
// its accept cycle. A snapshot walks the buttons from zero: a disabled
// button is skipped, an enabled one is read in ST_SCAN and written back in
// ST_SNAP_WR, and the walk stops after the last enabled button, or at the
// end of the table when none is enabled; the final result carries last.
// The state RAM read is registered. Configuration writes use
// cfg_valid/cfg_ready and are taken while busy and start are both low.
// Reset restores the register defaults and marks every RAM entry as
// cleared, so all buttons start with level, count and stamp at zero.
// ----------------------------------------------------------------------------
module button_change_lockout_debounce_top #(
    parameter int NUM_BUTTONS = bcl_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_BITS  = bcl_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcl_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [bcl_pkg::MASK_W-1:0]      cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [bcl_pkg::PIN_W-1:0]       pin,
    input  logic                            level,
    input  logic [bcl_pkg::MASK_W-1:0]      pin_levels,
    input  logic [bcl_pkg::TIME_W-1:0]      time_ms,
    output logic                            done,
    output logic [bcl_pkg::PIN_W-1:0]       button,
    output logic                            pressed,
    output logic                            button_level,
    output logic [bcl_pkg::CHANGE_W-1:0]    changes,
    output logic                            park_led,
    output logic                            last
);

    bcl_pkg::cfg_t cfg;

    // Configuration registers.
    bcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Read-modify-write sequencer with the state RAM.
    bcl_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .pin          (pin),
        .level        (level),
        .pin_levels   (pin_levels),
        .time_ms      (time_ms),
        .done         (done),
        .button       (button),
        .pressed      (pressed),
        .button_level (button_level),
        .changes      (changes),
        .park_led     (park_led),
        .last         (last)
    );

    // A snapshot request always occupies the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == bcl_pkg::CMD_SNAPSHOT)) |=> busy)
        else $error("snapshot request did not start the walk");

    // The final result of a request is issued once the sequencer is idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("final result issued while the sequencer is still busy");

    // Intermediate snapshot results only occur during a walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> busy)
        else $error("intermediate result issued outside a snapshot walk");

endmodule
